>>> sv/multi_pattern_string_matcher_core_defines.svh
// assertion macros used by the matcher datapath
`ifndef MULTI_PATTERN_STRING_MATCHER_CORE_DEFINES_SVH
`define MULTI_PATTERN_STRING_MATCHER_CORE_DEFINES_SVH

// condition that holds at every edge out of reset
`define MPSM_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("matcher invariant violated");

// condition that follows in the cycle after a trigger
`define MPSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("matcher sequence violated");

`endif

>>> sv/mpsm_pkg.sv
package mpsm_pkg;

  // default sizes
  localparam int DEF_MAX_NODES    = 128;
  localparam int DEF_ALPHABET     = 256;
  localparam int DEF_MAX_PATTERNS = 16;
  localparam int DEF_POS_BITS     = 16;
  localparam int RESULT_CAP       = 16;

  // func codes
  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_PAT   = 2'd1;
  localparam logic [1:0] FN_TEXT  = 2'd2;

  // controller states, also the datapath command
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] ST_DISP     = 5'd1;
  localparam logic [ST_W-1:0] ST_CLR      = 5'd2;
  localparam logic [ST_W-1:0] ST_SWEEP    = 5'd3;
  localparam logic [ST_W-1:0] ST_P_RD     = 5'd4;
  localparam logic [ST_W-1:0] ST_P_DEC    = 5'd5;
  localparam logic [ST_W-1:0] ST_P_ACC_RD = 5'd6;
  localparam logic [ST_W-1:0] ST_P_LAST   = 5'd7;
  localparam logic [ST_W-1:0] ST_B_INIT   = 5'd8;
  localparam logic [ST_W-1:0] ST_B_RRD    = 5'd9;
  localparam logic [ST_W-1:0] ST_B_RCHK   = 5'd10;
  localparam logic [ST_W-1:0] ST_B_DEQ    = 5'd11;
  localparam logic [ST_W-1:0] ST_B_T      = 5'd12;
  localparam logic [ST_W-1:0] ST_B_CRD    = 5'd13;
  localparam logic [ST_W-1:0] ST_B_CCHK   = 5'd14;
  localparam logic [ST_W-1:0] ST_B_R      = 5'd15;
  localparam logic [ST_W-1:0] ST_B_WALK   = 5'd16;
  localparam logic [ST_W-1:0] ST_B_WCHK   = 5'd17;
  localparam logic [ST_W-1:0] ST_B_WF     = 5'd18;
  localparam logic [ST_W-1:0] ST_B_AF     = 5'd19;
  localparam logic [ST_W-1:0] ST_B_AV     = 5'd20;
  localparam logic [ST_W-1:0] ST_T_START  = 5'd21;
  localparam logic [ST_W-1:0] ST_T_GRD    = 5'd22;
  localparam logic [ST_W-1:0] ST_T_GCHK   = 5'd23;
  localparam logic [ST_W-1:0] ST_T_FL     = 5'd24;
  localparam logic [ST_W-1:0] ST_T_ARD    = 5'd25;
  localparam logic [ST_W-1:0] ST_T_UPD    = 5'd26;
  localparam logic [ST_W-1:0] ST_E_OUT    = 5'd27;

  // controller to datapath
  typedef struct packed {
    logic [ST_W-1:0] op;
    logic            take;
  } mpsm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       last;
    logic       bad_sym;
    logic       links_built;
    logic       sweep_done;
    logic       g_zero;
    logic       r_zero;
    logic       wn_zero;
    logic       ch_last;
    logic       q_empty;
    logic       pat_none;
    logic       emit_last;
    logic       out_free;
  } mpsm_sts_t;

endpackage

>>> sv/multi_pattern_string_matcher_core.sv
// channel   signals                                   direction
// input     in_valid in_stall func symbol last        in, stall out
// output    out_valid out_stall pattern_index         out, stall in
//           start_position overflow last_result
//
// pattern symbol: goto read, then decode and write; the closing symbol then reads
// and writes the accept mask. text symbol: goto lookup plus a failure hop per miss
// on the goto and failure memories, then accept read; a bad symbol skips the lookup.
// a link build scans ALPHABET-1 goto entries per node and walks the failure links
// for each child found.
// end of text: one result per loaded pattern (max 16), one per cycle unless stalled.
// reset and clear sweep all MAX_NODES*ALPHABET goto entries (32768 by default)
// with input stalled; output stall only holds the result register and emission.
module multi_pattern_string_matcher_core import mpsm_pkg::*; #(
  parameter int MAX_NODES    = DEF_MAX_NODES,
  parameter int ALPHABET     = DEF_ALPHABET,
  parameter int MAX_PATTERNS = DEF_MAX_PATTERNS,
  parameter int POS_BITS     = DEF_POS_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic [7:0]         symbol,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         pattern_index,
  output logic signed [16:0] start_position,
  output logic               overflow,
  output logic               last_result
);

  mpsm_cmd_t cmd;
  mpsm_sts_t sts;

  // sequencer
  mpsm_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .sts(sts), .cmd(cmd)
  );

  // tables, counters and result register
  mpsm_dp #(
    .MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET),
    .MAX_PATTERNS(MAX_PATTERNS), .POS_BITS(POS_BITS)
  ) u_dp (
    .clk(clk), .rst(rst), .func(func), .symbol(symbol), .last(last),
    .cmd(cmd), .sts(sts), .out_valid(out_valid), .out_stall(out_stall),
    .pattern_index(pattern_index), .start_position(start_position),
    .overflow(overflow), .last_result(last_result)
  );

endmodule

>>> sv/mpsm_ram.sv
module mpsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/mpsm_ctrl.sv
module mpsm_ctrl import mpsm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  mpsm_sts_t sts,
  output mpsm_cmd_t cmd
);

  logic [ST_W-1:0] state, state_next;

  assign in_stall = (state != ST_IDLE);
  assign cmd.op   = state;
  assign cmd.take = in_valid && (state == ST_IDLE);

  // sequencing
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:     if (cmd.take) state_next = ST_DISP;
      ST_DISP: begin
        case (sts.func)
          FN_CLEAR: state_next = ST_CLR;
          FN_PAT:   state_next = ST_P_RD;
          FN_TEXT:  state_next = sts.links_built ? ST_T_START : ST_B_INIT;
          default:  state_next = ST_IDLE;
        endcase
      end
      ST_CLR:      state_next = ST_SWEEP;
      ST_SWEEP:    if (sts.sweep_done) state_next = ST_IDLE;
      ST_P_RD:     state_next = ST_P_DEC;
      ST_P_DEC:    state_next = sts.last ? ST_P_ACC_RD : ST_IDLE;
      ST_P_ACC_RD: state_next = ST_P_LAST;
      ST_P_LAST:   state_next = ST_IDLE;
      ST_B_INIT:   state_next = ST_B_RRD;
      ST_B_RRD:    state_next = ST_B_RCHK;
      ST_B_RCHK:   state_next = sts.ch_last ? ST_B_DEQ : ST_B_RRD;
      ST_B_DEQ:    state_next = sts.q_empty ? ST_T_START : ST_B_T;
      ST_B_T:      state_next = ST_B_CRD;
      ST_B_CRD:    state_next = ST_B_CCHK;
      ST_B_CCHK: begin
        if (!sts.g_zero) state_next = ST_B_R;
        else state_next = sts.ch_last ? ST_B_DEQ : ST_B_CRD;
      end
      ST_B_R:      state_next = ST_B_WALK;
      ST_B_WALK:   state_next = ST_B_WCHK;
      ST_B_WCHK:   state_next = (!sts.g_zero || sts.r_zero) ? ST_B_AF : ST_B_WF;
      ST_B_WF:     state_next = ST_B_WALK;
      ST_B_AF:     state_next = ST_B_AV;
      ST_B_AV:     state_next = sts.ch_last ? ST_B_DEQ : ST_B_CRD;
      ST_T_START:  state_next = sts.bad_sym ? ST_T_ARD : ST_T_GRD;
      ST_T_GRD:    state_next = ST_T_GCHK;
      ST_T_GCHK:   state_next = (!sts.g_zero || sts.wn_zero) ? ST_T_ARD : ST_T_FL;
      ST_T_FL:     state_next = ST_T_GRD;
      ST_T_ARD:    state_next = ST_T_UPD;
      ST_T_UPD: begin
        if (sts.last && !sts.pat_none) state_next = ST_E_OUT;
        else state_next = ST_IDLE;
      end
      ST_E_OUT:    if (sts.out_free && sts.emit_last) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> sv/mpsm_dp.sv
`include "multi_pattern_string_matcher_core_defines.svh"

module mpsm_dp import mpsm_pkg::*; #(
  parameter int MAX_NODES    = DEF_MAX_NODES,
  parameter int ALPHABET     = DEF_ALPHABET,
  parameter int MAX_PATTERNS = DEF_MAX_PATTERNS,
  parameter int POS_BITS     = DEF_POS_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         func,
  input  logic [7:0]         symbol,
  input  logic               last,
  input  mpsm_cmd_t          cmd,
  output mpsm_sts_t          sts,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [3:0]         pattern_index,
  output logic signed [16:0] start_position,
  output logic               overflow,
  output logic               last_result
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int GDEPTH = MAX_NODES * ALPHABET;
  localparam int GAW    = $clog2(GDEPTH);
  localparam int PC_W   = $clog2(MAX_PATTERNS + 1);
  localparam int PI_W   = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
  localparam int SW     = (POS_BITS + 1 > 8) ? POS_BITS + 1 : 9;

  // latched input item
  logic [1:0] func_r;
  logic [7:0] sym_r;
  logic       last_r;

  // automaton and pattern state
  logic [NODE_W-1:0]       cur, ins, wn, t, v, r;
  logic [NODE_W:0]         node_cnt;
  logic [PC_W-1:0]         pat_cnt;
  logic [POS_BITS-1:0]     pos;
  logic                    links, ovf, drop, dead;
  logic [7:0]              pend_len;
  logic [7:0]              ch;
  logic [NODE_W-1:0]       head, tail;
  logic [MAX_PATTERNS-1:0] accf;
  logic [GAW-1:0]          sweep;
  logic [PI_W-1:0]         j;
  logic [7:0]              plen   [MAX_PATTERNS];
  logic [POS_BITS-1:0]     fp_pos [MAX_PATTERNS];
  logic [MAX_PATTERNS-1:0] found;

  // memory ports
  logic                    g_we, f_we, a_we, q_we;
  logic [GAW-1:0]          g_waddr, g_raddr;
  logic [NODE_W-1:0]       g_wdata, g_q;
  logic [NODE_W-1:0]       f_waddr, f_raddr, f_wdata, f_q;
  logic [NODE_W-1:0]       a_waddr, a_raddr;
  logic [MAX_PATTERNS-1:0] a_wdata, a_q;
  logic [NODE_W-1:0]       q_wdata, q_q;

  logic                    bad, alloc, out_free, emit_last, sweep_low;
  logic [NODE_W-1:0]       fnew;
  logic [MAX_PATTERNS-1:0] pat_bit;
  logic [SW-1:0]           p1;
  logic [SW-1:0]           st [MAX_PATTERNS];
  logic [MAX_PATTERNS-1:0] ge;
  logic [PI_W+3:0]         jx;
  logic [POS_BITS+16:0]    posx;
  int                      emit_cnt;

  function automatic logic [GAW-1:0] gaddr(input logic [NODE_W-1:0] n,
                                           input logic [7:0] c);
    gaddr = GAW'(n) * GAW'(ALPHABET) + GAW'(c);
  endfunction

  // decode
  assign bad       = (sym_r == 8'd0) || (32'(sym_r) >= ALPHABET);
  assign alloc     = (cmd.op == ST_P_DEC) && !drop && !bad && !dead &&
                     (g_q == '0) && (32'(node_cnt) < MAX_NODES);
  assign fnew      = (g_q == v) ? '0 : g_q;
  assign pat_bit   = MAX_PATTERNS'(1) << pat_cnt;
  assign out_free  = !out_valid || !out_stall;
  assign emit_cnt  = (32'(pat_cnt) > RESULT_CAP) ? RESULT_CAP : 32'(pat_cnt);
  assign emit_last = (32'(j) + 1 == emit_cnt);
  assign sweep_low = (32'(sweep) < MAX_NODES);

  // start positions for every pattern ending at this symbol
  assign p1 = SW'(pos) + SW'(1);
  always_comb begin
    for (int k = 0; k < MAX_PATTERNS; k++) begin
      st[k] = p1 - SW'(plen[k]);
      ge[k] = (p1 >= SW'(plen[k]));
    end
  end

  // status
  assign sts.func        = func_r;
  assign sts.last        = last_r;
  assign sts.bad_sym     = bad;
  assign sts.links_built = links;
  assign sts.sweep_done  = (sweep == GAW'(GDEPTH - 1));
  assign sts.g_zero      = (g_q == '0);
  assign sts.r_zero      = (r == '0);
  assign sts.wn_zero     = (wn == '0);
  assign sts.ch_last     = (ch == 8'(ALPHABET - 1));
  assign sts.q_empty     = (head == tail);
  assign sts.pat_none    = (pat_cnt == '0);
  assign sts.emit_last   = emit_last;
  assign sts.out_free    = out_free;

  // memory port steering
  always_comb begin
    g_we = 1'b0; g_waddr = sweep; g_wdata = '0; g_raddr = gaddr(ins, sym_r);
    f_we = 1'b0; f_waddr = sweep[NODE_W-1:0]; f_wdata = '0; f_raddr = t;
    a_we = 1'b0; a_waddr = sweep[NODE_W-1:0]; a_wdata = '0; a_raddr = cur;
    q_we = 1'b0; q_wdata = g_q;
    case (cmd.op)
      ST_SWEEP: begin
        g_we = 1'b1;
        f_we = sweep_low;
        a_we = sweep_low;
      end
      ST_P_RD: g_raddr = gaddr(ins, sym_r);
      ST_P_DEC: begin
        g_we    = alloc;
        g_waddr = gaddr(ins, sym_r);
        g_wdata = node_cnt[NODE_W-1:0];
        f_we    = alloc;
        f_waddr = node_cnt[NODE_W-1:0];
        a_we    = alloc;
        a_waddr = node_cnt[NODE_W-1:0];
      end
      ST_P_ACC_RD: a_raddr = ins;
      ST_P_LAST: begin
        a_we    = !drop && !dead && (32'(pat_cnt) < MAX_PATTERNS);
        a_waddr = ins;
        a_wdata = a_q | pat_bit;
      end
      ST_B_RRD: g_raddr = gaddr('0, ch);
      ST_B_RCHK: begin
        f_we    = (g_q != '0);
        f_waddr = g_q;
        q_we    = (g_q != '0);
      end
      ST_B_CRD: g_raddr = gaddr(t, ch);
      ST_B_CCHK: begin
        q_we    = (g_q != '0);
        f_raddr = t;
      end
      ST_B_WALK: g_raddr = gaddr(r, ch);
      ST_B_WCHK: begin
        f_we    = (g_q != '0) || (r == '0);
        f_waddr = v;
        f_wdata = fnew;
        f_raddr = r;
        a_raddr = fnew;
      end
      ST_B_AF: a_raddr = v;
      ST_B_AV: begin
        a_we    = 1'b1;
        a_waddr = v;
        a_wdata = a_q | accf;
      end
      ST_T_GRD:  g_raddr = gaddr(wn, sym_r);
      ST_T_GCHK: f_raddr = wn;
      ST_T_ARD:  a_raddr = cur;
      default: ;
    endcase
  end

  // goto table, one row per node
  mpsm_ram #(.WIDTH(NODE_W), .DEPTH(GDEPTH)) u_goto (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_q)
  );

  // failure links
  mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_q)
  );

  // accept masks
  mpsm_ram #(.WIDTH(MAX_PATTERNS), .DEPTH(MAX_NODES)) u_acc (
    .clk(clk), .we(a_we), .waddr(a_waddr), .wdata(a_wdata),
    .raddr(a_raddr), .rdata(a_q)
  );

  // breadth-first queue
  mpsm_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
    .clk(clk), .we(q_we), .waddr(tail), .wdata(q_wdata),
    .raddr(head), .rdata(q_q)
  );

  // result fields
  assign jx   = {4'b0, j};
  assign posx = {17'b0, fp_pos[j]};

  // control and data registers
  always_ff @(posedge clk) begin
    if (rst || cmd.op == ST_CLR) begin
      cur      <= '0;
      ins      <= '0;
      node_cnt <= (NODE_W + 1)'(1);
      pat_cnt  <= '0;
      pos      <= '0;
      links    <= 1'b0;
      ovf      <= 1'b0;
      drop     <= 1'b0;
      dead     <= 1'b0;
      pend_len <= '0;
      found    <= '0;
      sweep    <= '0;
      head     <= '0;
      tail     <= '0;
      j        <= '0;
    end else begin
      case (cmd.op)
        ST_SWEEP: sweep <= sweep + GAW'(1);
        ST_P_RD: begin
          if (pend_len == '0 && !drop && !dead && 32'(pat_cnt) >= MAX_PATTERNS) begin
            drop <= 1'b1;
            ovf  <= 1'b1;
          end
        end
        ST_P_DEC: begin
          if (!drop) begin
            if (pend_len != 8'hFF) pend_len <= pend_len + 8'd1;
            if (bad) begin
              dead <= 1'b1;
            end else if (!dead) begin
              if (g_q != '0) begin
                ins <= g_q;
              end else if (alloc) begin
                node_cnt <= node_cnt + (NODE_W + 1)'(1);
                links    <= 1'b0;
                ins      <= node_cnt[NODE_W-1:0];
              end else begin
                drop <= 1'b1;
                ovf  <= 1'b1;
              end
            end
          end
        end
        ST_P_LAST: begin
          if (!drop && 32'(pat_cnt) < MAX_PATTERNS) begin
            if (!dead) links <= 1'b0;
            plen[pat_cnt[PI_W-1:0]] <= pend_len;
            pat_cnt <= pat_cnt + PC_W'(1);
          end
          ins      <= '0;
          pend_len <= '0;
          drop     <= 1'b0;
          dead     <= 1'b0;
        end
        ST_B_INIT: begin
          ch   <= 8'd1;
          head <= '0;
          tail <= '0;
        end
        ST_B_RCHK: begin
          if (g_q != '0) tail <= tail + NODE_W'(1);
          if (!sts.ch_last) ch <= ch + 8'd1;
        end
        ST_B_DEQ: begin
          if (head == tail) links <= 1'b1;
          else head <= head + NODE_W'(1);
        end
        ST_B_T: begin
          t  <= q_q;
          ch <= 8'd1;
        end
        ST_B_CCHK: begin
          if (g_q != '0) begin
            v    <= g_q;
            tail <= tail + NODE_W'(1);
          end else if (!sts.ch_last) begin
            ch <= ch + 8'd1;
          end
        end
        ST_B_R, ST_B_WF: r <= f_q;
        ST_B_AF: accf <= a_q;
        ST_B_AV: if (!sts.ch_last) ch <= ch + 8'd1;
        ST_T_START: begin
          if (bad) cur <= '0;
          else wn <= cur;
        end
        ST_T_GCHK: if (g_q != '0 || wn == '0) cur <= g_q;
        ST_T_FL: wn <= f_q;
        ST_T_UPD: begin
          j <= '0;
          // rearm right away when nothing is to be reported
          if (last_r && pat_cnt == '0) begin
            cur   <= '0;
            pos   <= '0;
            found <= '0;
          end else begin
            for (int k = 0; k < MAX_PATTERNS; k++) begin
              if (a_q[k] && !found[k] && k < 32'(pat_cnt)) begin
                found[k]  <= 1'b1;
                fp_pos[k] <= ge[k] ? POS_BITS'(st[k]) : '0;
              end
            end
            if (pos != '1) pos <= pos + POS_BITS'(1);
          end
        end
        ST_E_OUT: begin
          if (out_free) begin
            if (emit_last) begin
              cur   <= '0;
              pos   <= '0;
              found <= '0;
            end else begin
              j <= j + PI_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
    if (cmd.take) begin
      func_r <= func;
      sym_r  <= symbol;
      last_r <= last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == ST_E_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == ST_E_OUT && out_free) begin
      pattern_index  <= jx[3:0];
      start_position <= found[j] ? posx[16:0] : '1;
      overflow       <= ovf;
      last_result    <= emit_last;
    end
  end

  `MPSM_ASSERT_ALWAYS(a_node_bound, node_cnt != '0 && 32'(node_cnt) <= MAX_NODES)
  `MPSM_ASSERT_ALWAYS(a_pat_bound, 32'(pat_cnt) <= MAX_PATTERNS)
  `MPSM_ASSERT_NEXT(a_emit_load, cmd.op == ST_E_OUT && out_free, out_valid)

endmodule
